>>> hdl/ipx_pkg.sv
// ----------------------------------------------------------------------------
// ipx_pkg
// Shared constants and types of the indexed pixel palette expander.
// ----------------------------------------------------------------------------
package ipx_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
	localparam int COUNT_W         = 9;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	localparam logic [1:0] REG_KEY_ENABLE    = 2'd0;
	localparam logic [1:0] REG_KEY_COLOR     = 2'd1;
	localparam logic [1:0] REG_PALETTE_COUNT = 2'd2;

	localparam logic        KEY_ENABLE_RST    = 1'b1;
	localparam logic [15:0] KEY_COLOR_RST     = 16'hF81F;
	localparam logic [8:0]  PALETTE_COUNT_RST = 9'd256;

	typedef struct packed {
		logic [15:0] color;
		logic        eoi;
	} pix_t;

	typedef struct packed {
		logic        key_enable;
		logic [15:0] key_color;
		logic [8:0]  palette_count;
	} cfg_t;

endpackage

>>> hdl/ipx_ram.sv
// ----------------------------------------------------------------------------
// ipx_ram
// Generic single-port RAM, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module ipx_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

>>> hdl/ipx_front.sv
// ----------------------------------------------------------------------------
// ipx_front
// Accepts items, stores palette writes, looks up pixel indexes.
// ----------------------------------------------------------------------------
module ipx_front import ipx_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              kind,
	input  logic [7:0]        entry_index,
	input  logic [15:0]       color565,
	input  logic              end_of_image,
	input  cfg_t              cfg,
	input  logic [QCNT_W-1:0] q_count,
	output logic              q_push,
	output pix_t              q_data
);

	logic              accept;
	logic              in_cap;
	logic [8:0]        count_eff;
	logic              in_range;
	logic              ram_we;
	logic              ram_re;
	logic [15:0]       ram_rdata;
	logic              valid_s1;
	logic              in_range_s1;
	logic              eoi_s1;
	logic [QCNT_W:0]   load;

	assign load   = {1'b0, q_count} + {{QCNT_W{1'b0}}, valid_s1};
	assign full   = (load >= (QCNT_W + 1)'(QDEPTH));
	assign accept = push && !full;

	assign in_cap    = ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));
	assign count_eff = (cfg.palette_count > 9'(PALETTE_ENTRIES)) ?
		9'(PALETTE_ENTRIES) : cfg.palette_count;
	assign in_range  = ({1'b0, entry_index} < count_eff) && in_cap;

	assign ram_we = accept && (kind == KIND_WRITE) && in_cap;
	assign ram_re = accept && (kind == KIND_PIXEL);

	ipx_ram #(
		.WIDTH(16),
		.DEPTH(PALETTE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (entry_index[IDX_W-1:0]),
		.wdata (color565),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			in_range_s1 <= in_range;
			eoi_s1      <= end_of_image;
		end
	end

	assign q_push       = valid_s1;
	assign q_data.color = in_range_s1 ? ram_rdata : cfg.key_color;
	assign q_data.eoi   = eoi_s1;

endmodule

>>> hdl/ipx_fifo.sv
// ----------------------------------------------------------------------------
// ipx_fifo
// Short queue of looked-up pixels between front and back.
// ----------------------------------------------------------------------------
module ipx_fifo import ipx_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pix_t              wdata,
	input  logic              pop,
	output pix_t              rdata,
	output logic              not_empty,
	output logic [QCNT_W-1:0] count
);

	pix_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign not_empty = (count_q != '0);
	assign rdata     = slot_q[rptr_q];
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wdata;
		end
	end

endmodule

>>> hdl/ipx_back.sv
// ----------------------------------------------------------------------------
// ipx_back
// Expands RGB565 to RGBA8, applies the color key, holds the result register.
// ----------------------------------------------------------------------------
module ipx_back import ipx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  pix_t        q_data,
	input  logic        q_not_empty,
	output logic        q_pop,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        last_pixel
);

	logic       out_valid_q;
	logic       load;
	logic       keyed;
	logic [4:0] r5;
	logic [5:0] g6;
	logic [4:0] b5;

	assign empty = !out_valid_q;
	assign load  = q_not_empty && (!out_valid_q || pop);
	assign q_pop = load;

	assign r5    = q_data.color[15:11];
	assign g6    = q_data.color[10:5];
	assign b5    = q_data.color[4:0];
	assign keyed = cfg.key_enable && (q_data.color == cfg.key_color);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_pixel <= q_data.eoi;
			if (keyed) begin
				red   <= 8'd0;
				green <= 8'd0;
				blue  <= 8'd0;
				alpha <= 8'd0;
			end else begin
				red   <= {r5, r5[4:2]};
				green <= {g6, g6[5:4]};
				blue  <= {b5, b5[4:2]};
				alpha <= 8'hFF;
			end
		end
	end

endmodule

>>> hdl/indexed_pixel_palette_expander.sv
// ----------------------------------------------------------------------------
// indexed_pixel_palette_expander
// Palette lookup of 8-bit pixel indexes into RGBA8 through an RGB565 palette.
// ----------------------------------------------------------------------------
// Takes one item per clock while full is low, palette writes and pixels
// alike: each item makes one access to the single-port palette RAM. A
// pixel's result passes the RAM read register, the queue and then the
// result register before it reaches the result ports; palette writes give
// no result. A four-entry queue between the lookup and the expander lets
// either side stall. Entries below the palette count must be written before
// pixels read them. Configuration must be written only while the block is
// idle, which the block does not enforce: index 0 key_enable (reset 1),
// index 1 key_color (reset 0xF81F), index 2 palette_count (reset 256).
module indexed_pixel_palette_expander import ipx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [7:0]  entry_index,
	input  logic [15:0] color565,
	input  logic        end_of_image,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        last_pixel,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t              cfg_q;
	logic [QCNT_W-1:0] q_count;
	logic              q_push;
	pix_t              q_wdata;
	pix_t              q_rdata;
	logic              q_pop;
	logic              q_not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_enable    <= KEY_ENABLE_RST;
			cfg_q.key_color     <= KEY_COLOR_RST;
			cfg_q.palette_count <= PALETTE_COUNT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KEY_ENABLE:    cfg_q.key_enable    <= cfg_data[0];
				REG_KEY_COLOR:     cfg_q.key_color     <= cfg_data;
				REG_PALETTE_COUNT: cfg_q.palette_count <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	ipx_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.entry_index  (entry_index),
		.color565     (color565),
		.end_of_image (end_of_image),
		.cfg          (cfg_q),
		.q_count      (q_count),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	ipx_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.pop       (q_pop),
		.rdata     (q_rdata),
		.not_empty (q_not_empty),
		.count     (q_count)
	);

	ipx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_data      (q_rdata),
		.q_not_empty (q_not_empty),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.alpha       (alpha),
		.last_pixel  (last_pixel)
	);

endmodule
